@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define CCP_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ccp assertion failed");

// Same-cycle implication built on the macro above.
`define CCP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    `CCP_ASSERT(name, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication built on the first macro.
`define CCP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    `CCP_ASSERT(name, clk, rst_n, (ante) |=> (cons))

`endif

@@ hw/rtl/ccp_pkg.sv @@
// Package for the three-point circumcircle block: widths, constants, stage types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ccp_pkg;

    localparam int IN_W       = 12;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_W      = 24;

    // front-end arithmetic
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int DIF_W  = COORD_BITS + 1;
    localparam int DP_W   = 2 * DIF_W;
    localparam int NP_W   = SQ_W + 1 + DIF_W;
    localparam int DEN_W  = DP_W + 2;
    localparam int NUM_W  = NP_W + 1;
    localparam int DENU_W = DEN_W - 1;
    localparam int NUMU_W = NUM_W - 1;

    // divider
    localparam int QCAP_LOG  = 26;
    localparam int QINT_W    = QCAP_LOG + 1;
    localparam int Q_W       = QINT_W + FRAC_BITS;
    localparam int CAP_W     = DENU_W + QCAP_LOG + 1;
    localparam int DIV_STEPS = Q_W;
    localparam logic [Q_W-1:0] CAP_M = Q_W'(1) << (QCAP_LOG + FRAC_BITS);

    // center and radius
    localparam int C_W      = Q_W + 1;
    localparam int DX_W     = C_W + 1;
    localparam int SQP_W    = 2 * OUT_W;
    localparam int SQS_W    = SQP_W + 1;
    localparam int SQ_STEPS = (SQS_W + 1) / 2;
    localparam logic [OUT_W-1:0] CTR_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] CTR_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] RAD_MAX = {OUT_W{1'b1}};

    // pipeline depth
    localparam int FRONT_ST = 6;
    localparam int MID_ST   = 6;
    localparam int NSTAGE   = FRONT_ST + DIV_STEPS + MID_ST + SQ_STEPS;

    typedef struct packed {
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
        logic [COORD_BITS-1:0] x3;
        logic [COORD_BITS-1:0] y3;
    } pts_t;

    typedef struct packed {
        logic [DENU_W-1:0] rem;
        logic [Q_W-1:0]    nq;
    } div_lane_t;

    typedef struct packed {
        logic [DENU_W-1:0]     ud;
        logic                  neg_x;
        logic                  neg_y;
        logic                  cap_x;
        logic                  cap_y;
        logic                  deg;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
    } div_side_t;

    typedef struct packed {
        logic [SQS_W-1:0] rem;
        logic [SQS_W-1:0] res;
    } sqrt_lane_t;

    typedef struct packed {
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
        logic             deg;
        logic             sat;
        logic             big;
    } sqrt_side_t;

endpackage

`default_nettype wire

@@ hw/rtl/circumcircle_three_points.sv @@
// Top level of the three-point circumcircle block: stage valids, cell chains, output skid.
// Depends on ccp_pkg, ccp_front, ccp_div_cell, ccp_mid, ccp_sqrt_cell.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------
//   input   | in_valid / in_ready   | first_x first_y second_x second_y third_x third_y
//   output  | out_valid / out_ready | center_x center_y circle_radius degenerate saturated
//
// One transaction in per cycle, one result out per cycle, sustained while out_ready holds.
// A result passes through 72 chain stages (6 front stages, 35 divider cells with one
// quotient bit each, 6 middle stages and 25 root cells with one root bit each) and then
// the output register.
// rst_n clears only the valid bits and the output/skid flags; payload flops run free.
// A stalled output parks one result in the skid register; in_ready drops the cycle
// after and the whole chain holds until the skid drains.
`default_nettype none

module circumcircle_three_points import ccp_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IN_W-1:0]         first_x,
    input  logic [IN_W-1:0]         first_y,
    input  logic [IN_W-1:0]         second_x,
    input  logic [IN_W-1:0]         second_y,
    input  logic [IN_W-1:0]         third_x,
    input  logic [IN_W-1:0]         third_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] center_x,
    output logic signed [OUT_W-1:0] center_y,
    output logic [OUT_W-1:0]        circle_radius,
    output logic                    degenerate,
    output logic                    saturated
);

    typedef struct packed {
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
        logic [OUT_W-1:0] rad;
        logic             deg;
        logic             sat;
    } res_t;

    logic              adv;
    logic [NSTAGE-1:0] v_reg;
    pts_t              pts;

    div_side_t  front_side;
    div_lane_t  front_lx, front_ly;
    div_side_t  dside [DIV_STEPS];
    div_lane_t  dlx [DIV_STEPS];
    div_lane_t  dly [DIV_STEPS];
    sqrt_lane_t mid_lane;
    sqrt_side_t mid_side;
    sqrt_lane_t slane [SQ_STEPS];
    sqrt_side_t sside [SQ_STEPS];

    sqrt_lane_t       last_lane;
    sqrt_side_t       last_side;
    logic [SQS_W-1:0] rad_full;
    logic             rad_sat;
    res_t             res_new;
    res_t             out_reg, skid_reg;
    logic             out_v_reg, skid_v_reg;
    logic             arrive;

    // The chain moves as one; it only holds while the skid register is occupied.
    assign adv      = !skid_v_reg;
    assign in_ready = adv;

    // Mask each coordinate to the working width.
    assign pts.x1 = COORD_BITS'(first_x);
    assign pts.y1 = COORD_BITS'(first_y);
    assign pts.x2 = COORD_BITS'(second_x);
    assign pts.y2 = COORD_BITS'(second_y);
    assign pts.x3 = COORD_BITS'(third_x);
    assign pts.y3 = COORD_BITS'(third_y);

    // Stage valid bits: shift with the chain, a bubble enters when no transaction does.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], in_valid};
        end
    end

    ccp_front u_front (
        .clk    (clk),
        .adv    (adv),
        .pts    (pts),
        .side   (front_side),
        .lane_x (front_lx),
        .lane_y (front_ly)
    );

    // Divider chain: each cell settles one quotient bit of both center lanes.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        if (i == 0)
        begin : g_head
            ccp_div_cell u_cell (
                .clk    (clk),
                .adv    (adv),
                .side_i (front_side),
                .lx_i   (front_lx),
                .ly_i   (front_ly),
                .side_o (dside[i]),
                .lx_o   (dlx[i]),
                .ly_o   (dly[i])
            );
        end
        else
        begin : g_body
            ccp_div_cell u_cell (
                .clk    (clk),
                .adv    (adv),
                .side_i (dside[i-1]),
                .lx_i   (dlx[i-1]),
                .ly_i   (dly[i-1]),
                .side_o (dside[i]),
                .lx_o   (dlx[i]),
                .ly_o   (dly[i])
            );
        end
    end

    ccp_mid u_mid (
        .clk    (clk),
        .adv    (adv),
        .side_i (dside[DIV_STEPS-1]),
        .lx_i   (dlx[DIV_STEPS-1]),
        .ly_i   (dly[DIV_STEPS-1]),
        .lane_o (mid_lane),
        .side_o (mid_side)
    );

    // Root chain: cell i tests the power of four for result bit SQ_STEPS-1-i.
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        if (i == 0)
        begin : g_head
            ccp_sqrt_cell u_cell (
                .clk      (clk),
                .adv      (adv),
                .step_bit (SQS_W'(1) << (2 * (SQ_STEPS - 1 - i))),
                .lane_i   (mid_lane),
                .side_i   (mid_side),
                .lane_o   (slane[i]),
                .side_o   (sside[i])
            );
        end
        else
        begin : g_body
            ccp_sqrt_cell u_cell (
                .clk      (clk),
                .adv      (adv),
                .step_bit (SQS_W'(1) << (2 * (SQ_STEPS - 1 - i))),
                .lane_i   (slane[i-1]),
                .side_i   (sside[i-1]),
                .lane_o   (slane[i]),
                .side_o   (sside[i])
            );
        end
    end

    assign last_lane = slane[SQ_STEPS-1];
    assign last_side = sside[SQ_STEPS-1];

    // Round the root to nearest, clip the radius, then build the result.
    always_comb
    begin
        rad_full = last_lane.res + SQS_W'(last_lane.rem > last_lane.res);
        rad_sat  = last_side.big || (rad_full > SQS_W'(RAD_MAX));
        if (last_side.deg)
        begin
            res_new.cx  = '0;
            res_new.cy  = '0;
            res_new.rad = '0;
            res_new.deg = 1'b1;
            res_new.sat = 1'b0;
        end
        else
        begin
            res_new.cx  = last_side.cx;
            res_new.cy  = last_side.cy;
            res_new.rad = rad_sat ? RAD_MAX : rad_full[OUT_W-1:0];
            res_new.deg = 1'b0;
            res_new.sat = last_side.sat || rad_sat;
        end
    end

    assign arrive = adv && v_reg[NSTAGE-1];

    // Output register plus skid: drain the skid first, park an arrival on a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ready)
        begin
            out_v_reg  <= skid_v_reg || arrive;
            skid_v_reg <= 1'b0;
        end
        else if (arrive)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ready)
        begin
            out_reg <= skid_v_reg ? skid_reg : res_new;
        end
        else if (arrive)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid     = out_v_reg;
    assign center_x      = out_reg.cx;
    assign center_y      = out_reg.cy;
    assign circle_radius = out_reg.rad;
    assign degenerate    = out_reg.deg;
    assign saturated     = out_reg.sat;

endmodule

`default_nettype wire

@@ hw/rtl/ccp_front.sv @@
// Front end: squares, differences, products, sums, magnitudes and quotient cap.
// Six register stages; depends on ccp_pkg.
`default_nettype none

module ccp_front import ccp_pkg::*; (
    input  logic      clk,
    input  logic      adv,
    input  pts_t      pts,
    output div_side_t side,
    output div_lane_t lane_x,
    output div_lane_t lane_y
);

    pts_t                     a_reg;
    pts_t                     b_reg;
    logic [SQ_W-1:0]          s1_reg, s2_reg, s3_reg;
    logic signed [DIF_W-1:0]  da_reg, db_reg, dc_reg, dd_reg, de_reg, df_reg;
    logic signed [DP_W-1:0]   t1_reg, t2_reg, t3_reg;
    logic signed [NP_W-1:0]   nx1_reg, nx2_reg, nx3_reg, ny1_reg, ny2_reg, ny3_reg;
    logic [COORD_BITS-1:0]    x1c_reg, y1c_reg, x1d_reg, y1d_reg, x1e_reg, y1e_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic signed [NUM_W-1:0]  nx_reg, ny_reg;
    logic [DENU_W-1:0]        ud_reg;
    logic [NUMU_W-1:0]        unx_reg, uny_reg;
    logic                     negx_reg, negy_reg, deg_reg;
    div_side_t                side_reg, side_next;
    div_lane_t                lx_reg, lx_next, ly_reg, ly_next;

    always_comb
    begin
        side_next.ud    = ud_reg;
        side_next.neg_x = negx_reg;
        side_next.neg_y = negy_reg;
        side_next.cap_x = CAP_W'(unx_reg) >= ((CAP_W'(ud_reg) << QCAP_LOG) + CAP_W'(ud_reg));
        side_next.cap_y = CAP_W'(uny_reg) >= ((CAP_W'(ud_reg) << QCAP_LOG) + CAP_W'(ud_reg));
        side_next.deg   = deg_reg;
        side_next.x1    = x1e_reg;
        side_next.y1    = y1e_reg;
        // integer part above QINT_W bits seeds the remainder
        lx_next.rem = DENU_W'(unx_reg >> QINT_W);
        lx_next.nq  = Q_W'(unx_reg) << FRAC_BITS;
        ly_next.rem = DENU_W'(uny_reg >> QINT_W);
        ly_next.nq  = Q_W'(uny_reg) << FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= pts;

            b_reg  <= a_reg;
            s1_reg <= SQ_W'(a_reg.x1) * SQ_W'(a_reg.x1) + SQ_W'(a_reg.y1) * SQ_W'(a_reg.y1);
            s2_reg <= SQ_W'(a_reg.x2) * SQ_W'(a_reg.x2) + SQ_W'(a_reg.y2) * SQ_W'(a_reg.y2);
            s3_reg <= SQ_W'(a_reg.x3) * SQ_W'(a_reg.x3) + SQ_W'(a_reg.y3) * SQ_W'(a_reg.y3);
            da_reg <= DIF_W'(a_reg.y2) - DIF_W'(a_reg.y3);
            db_reg <= DIF_W'(a_reg.y3) - DIF_W'(a_reg.y1);
            dc_reg <= DIF_W'(a_reg.y1) - DIF_W'(a_reg.y2);
            dd_reg <= DIF_W'(a_reg.x3) - DIF_W'(a_reg.x2);
            de_reg <= DIF_W'(a_reg.x1) - DIF_W'(a_reg.x3);
            df_reg <= DIF_W'(a_reg.x2) - DIF_W'(a_reg.x1);

            x1c_reg <= b_reg.x1;
            y1c_reg <= b_reg.y1;
            t1_reg  <= DP_W'($signed({1'b0, b_reg.x1})) * DP_W'(da_reg);
            t2_reg  <= DP_W'($signed({1'b0, b_reg.x2})) * DP_W'(db_reg);
            t3_reg  <= DP_W'($signed({1'b0, b_reg.x3})) * DP_W'(dc_reg);
            nx1_reg <= NP_W'($signed({1'b0, s1_reg})) * NP_W'(da_reg);
            nx2_reg <= NP_W'($signed({1'b0, s2_reg})) * NP_W'(db_reg);
            nx3_reg <= NP_W'($signed({1'b0, s3_reg})) * NP_W'(dc_reg);
            ny1_reg <= NP_W'($signed({1'b0, s1_reg})) * NP_W'(dd_reg);
            ny2_reg <= NP_W'($signed({1'b0, s2_reg})) * NP_W'(de_reg);
            ny3_reg <= NP_W'($signed({1'b0, s3_reg})) * NP_W'(df_reg);

            x1d_reg <= x1c_reg;
            y1d_reg <= y1c_reg;
            den_reg <= (DEN_W'(t1_reg) + DEN_W'(t2_reg) + DEN_W'(t3_reg)) <<< 1;
            nx_reg  <= NUM_W'(nx1_reg) + NUM_W'(nx2_reg) + NUM_W'(nx3_reg);
            ny_reg  <= NUM_W'(ny1_reg) + NUM_W'(ny2_reg) + NUM_W'(ny3_reg);

            x1e_reg  <= x1d_reg;
            y1e_reg  <= y1d_reg;
            ud_reg   <= DENU_W'(den_reg[DEN_W-1] ? -den_reg : den_reg);
            unx_reg  <= NUMU_W'(nx_reg[NUM_W-1] ? -nx_reg : nx_reg);
            uny_reg  <= NUMU_W'(ny_reg[NUM_W-1] ? -ny_reg : ny_reg);
            negx_reg <= nx_reg[NUM_W-1] ^ den_reg[DEN_W-1];
            negy_reg <= ny_reg[NUM_W-1] ^ den_reg[DEN_W-1];
            deg_reg  <= (den_reg == '0);

            side_reg <= side_next;
            lx_reg   <= lx_next;
            ly_reg   <= ly_next;
        end
    end

    assign side   = side_reg;
    assign lane_x = lx_reg;
    assign lane_y = ly_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ccp_div_cell.sv @@
// One restoring-division cell: one quotient bit for each of the two center lanes.
// Depends on ccp_pkg.
`default_nettype none

module ccp_div_cell import ccp_pkg::*; (
    input  logic      clk,
    input  logic      adv,
    input  div_side_t side_i,
    input  div_lane_t lx_i,
    input  div_lane_t ly_i,
    output div_side_t side_o,
    output div_lane_t lx_o,
    output div_lane_t ly_o
);

    div_side_t       side_reg;
    div_lane_t       lx_reg, lx_next, ly_reg, ly_next;
    logic [DENU_W:0] tx, ty, dvs;

    always_comb
    begin
        dvs = {1'b0, side_i.ud};
        tx  = {lx_i.rem, lx_i.nq[Q_W-1]};
        ty  = {ly_i.rem, ly_i.nq[Q_W-1]};
        // subtract the divisor where it fits, shift the quotient bit in
        if (tx >= dvs)
        begin
            lx_next.rem = DENU_W'(tx - dvs);
            lx_next.nq  = {lx_i.nq[Q_W-2:0], 1'b1};
        end
        else
        begin
            lx_next.rem = tx[DENU_W-1:0];
            lx_next.nq  = {lx_i.nq[Q_W-2:0], 1'b0};
        end
        if (ty >= dvs)
        begin
            ly_next.rem = DENU_W'(ty - dvs);
            ly_next.nq  = {ly_i.nq[Q_W-2:0], 1'b1};
        end
        else
        begin
            ly_next.rem = ty[DENU_W-1:0];
            ly_next.nq  = {ly_i.nq[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg <= side_i;
            lx_reg   <= lx_next;
            ly_reg   <= ly_next;
        end
    end

    assign side_o = side_reg;
    assign lx_o   = lx_reg;
    assign ly_o   = ly_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ccp_mid.sv @@
// Middle section: quotient rounding, sign, offset to the first point, clipping,
// squares and their sum. Six register stages; depends on ccp_pkg.
`default_nettype none

module ccp_mid import ccp_pkg::*; (
    input  logic       clk,
    input  logic       adv,
    input  div_side_t  side_i,
    input  div_lane_t  lx_i,
    input  div_lane_t  ly_i,
    output sqrt_lane_t lane_o,
    output sqrt_side_t side_o
);

    logic [Q_W-1:0]          mx_reg, my_reg, mx_next, my_next;
    logic                    negx_reg, negy_reg;
    logic                    deg1_reg, deg2_reg;
    logic [COORD_BITS-1:0]   x1a_reg, y1a_reg, x1b_reg, y1b_reg;
    logic signed [C_W-1:0]   cx_reg, cy_reg;
    logic signed [DX_W-1:0]  dx_reg, dy_reg;
    logic [DX_W-1:0]         adx, ady;
    logic                    okx, oky;
    sqrt_side_t              s3_reg, s3_next, s4_reg, s4_next, s5_reg, s6_reg;
    logic [OUT_W-1:0]        adx_reg, ady_reg;
    logic [SQP_W-1:0]        sqx_reg, sqy_reg;
    sqrt_lane_t              lane_reg;

    always_comb
    begin
        mx_next = side_i.cap_x ? CAP_M :
                  lx_i.nq + Q_W'({lx_i.rem, 1'b0} >= {1'b0, side_i.ud});
        my_next = side_i.cap_y ? CAP_M :
                  ly_i.nq + Q_W'({ly_i.rem, 1'b0} >= {1'b0, side_i.ud});

        // center fits the output when its top bits are all sign
        okx = (cx_reg[C_W-1:OUT_W-1] == '0) || (cx_reg[C_W-1:OUT_W-1] == '1);
        oky = (cy_reg[C_W-1:OUT_W-1] == '0) || (cy_reg[C_W-1:OUT_W-1] == '1);
        s3_next.cx  = okx ? cx_reg[OUT_W-1:0] : (cx_reg[C_W-1] ? CTR_MIN : CTR_MAX);
        s3_next.cy  = oky ? cy_reg[OUT_W-1:0] : (cy_reg[C_W-1] ? CTR_MIN : CTR_MAX);
        s3_next.deg = deg2_reg;
        s3_next.sat = !okx || !oky;
        s3_next.big = 1'b0;

        adx = dx_reg[DX_W-1] ? DX_W'(-dx_reg) : DX_W'(dx_reg);
        ady = dy_reg[DX_W-1] ? DX_W'(-dy_reg) : DX_W'(dy_reg);

        s4_next     = s3_reg;
        s4_next.big = (adx[DX_W-1:OUT_W] != '0) || (ady[DX_W-1:OUT_W] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            negx_reg <= side_i.neg_x;
            negy_reg <= side_i.neg_y;
            deg1_reg <= side_i.deg;
            x1a_reg  <= side_i.x1;
            y1a_reg  <= side_i.y1;

            cx_reg   <= negx_reg ? -C_W'(mx_reg) : C_W'(mx_reg);
            cy_reg   <= negy_reg ? -C_W'(my_reg) : C_W'(my_reg);
            deg2_reg <= deg1_reg;
            x1b_reg  <= x1a_reg;
            y1b_reg  <= y1a_reg;

            dx_reg <= DX_W'(cx_reg) - (DX_W'(x1b_reg) << FRAC_BITS);
            dy_reg <= DX_W'(cy_reg) - (DX_W'(y1b_reg) << FRAC_BITS);
            s3_reg <= s3_next;

            adx_reg <= adx[OUT_W-1:0];
            ady_reg <= ady[OUT_W-1:0];
            s4_reg  <= s4_next;

            sqx_reg <= SQP_W'(adx_reg) * SQP_W'(adx_reg);
            sqy_reg <= SQP_W'(ady_reg) * SQP_W'(ady_reg);
            s5_reg  <= s4_reg;

            lane_reg <= '{rem: SQS_W'(sqx_reg) + SQS_W'(sqy_reg), res: '0};
            s6_reg   <= s5_reg;
        end
    end

    assign lane_o = lane_reg;
    assign side_o = s6_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ccp_sqrt_cell.sv @@
// One square-root cell: one result bit of the digit-by-digit integer root.
// Depends on ccp_pkg.
`default_nettype none

module ccp_sqrt_cell import ccp_pkg::*; (
    input  logic             clk,
    input  logic             adv,
    input  logic [SQS_W-1:0] step_bit,
    input  sqrt_lane_t       lane_i,
    input  sqrt_side_t       side_i,
    output sqrt_lane_t       lane_o,
    output sqrt_side_t       side_o
);

    sqrt_lane_t     lane_reg, lane_next;
    sqrt_side_t     side_reg;
    logic [SQS_W:0] trial;

    always_comb
    begin
        trial = {1'b0, lane_i.res} + {1'b0, step_bit};
        if ({1'b0, lane_i.rem} >= trial)
        begin
            lane_next.rem = lane_i.rem - trial[SQS_W-1:0];
            lane_next.res = (lane_i.res >> 1) + step_bit;
        end
        else
        begin
            lane_next.rem = lane_i.rem;
            lane_next.res = lane_i.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg <= lane_next;
            side_reg <= side_i;
        end
    end

    assign lane_o = lane_reg;
    assign side_o = side_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ccp_checker.sv @@
// Port-level checker for the circumcircle block, bound to its top level.
// Depends on assert_macros.svh and ccp_pkg.
`default_nettype none
`include "assert_macros.svh"

module ccp_checker import ccp_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] center_x,
    input logic [OUT_W-1:0] center_y,
    input logic [OUT_W-1:0] circle_radius,
    input logic             degenerate,
    input logic             saturated
);

    `CCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `CCP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
        $stable(center_x) && $stable(center_y) && $stable(circle_radius)
        && $stable(degenerate) && $stable(saturated))
    `CCP_ASSERT_IMPL(a_deg_zero, clk, rst_n, out_valid && degenerate,
        center_x == '0 && center_y == '0 && circle_radius == '0 && !saturated)
    `CCP_ASSERT_IMPL(a_ready_drop, clk, rst_n, $fell(in_ready), $past(out_valid && !out_ready))
    `CCP_ASSERT_IMPL(a_busy_full, clk, rst_n, !in_ready, out_valid)

endmodule

bind circumcircle_three_points ccp_checker u_ccp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .center_x      (center_x),
    .center_y      (center_y),
    .circle_radius (circle_radius),
    .degenerate    (degenerate),
    .saturated     (saturated)
);

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for circumcircle_three_points: directed and random point triples with random idling.
// Depends on ccp_pkg and the circumcircle_three_points RTL; reads no files.
`default_nettype none

module tb;
    import ccp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected result of one triple
    typedef struct {
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic [OUT_W-1:0]        rad;
        logic                    deg;
        logic                    sat;
    } circle_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [IN_W-1:0]         first_x, first_y, second_x, second_y, third_x, third_y;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] center_x, center_y;
    logic [OUT_W-1:0]        circle_radius;
    logic                    degenerate, saturated;

    circle_t pending_circles[$];
    int      n_errors;
    int      n_sent;
    int      n_checked;
    int      n_degen;
    int      n_clipped;
    bit      calm;      // no idling on either side in the final stretch

    circumcircle_three_points u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_x(first_x), .first_y(first_y),
        .second_x(second_x), .second_y(second_y),
        .third_x(third_x), .third_y(third_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .center_x(center_x), .center_y(center_y),
        .circle_radius(circle_radius),
        .degenerate(degenerate), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Generous watchdog for about 850 items with stalls
    initial
    begin
        #400000;
        $display("FAIL circumcircle_three_points");
        $finish;
    end

    // Rounded fixed-point quotient, ties away from zero, magnitude capped at 2^26
    function automatic longint fixed_quotient(longint num, longint den);
        bit     neg;
        longint un, ud, q, r, m;
        neg = (num < 0) != (den < 0);
        un  = num < 0 ? -num : num;
        ud  = den < 0 ? -den : den;
        q   = un / ud;
        r   = un % ud;
        if (q > 64'd67108864)
        begin
            q = 67108864;
            r = 0;
        end
        m = q;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            r = r << 1;
            m = m << 1;
            if (r >= ud)
            begin
                r = r - ud;
                m = m | 1;
            end
        end
        if ((r << 1) >= ud)
            m = m + 1;
        return neg ? -m : m;
    endfunction

    // Integer square root rounded to nearest
    function automatic longint unsigned nearest_root(longint unsigned s);
        longint unsigned rem, res, b;
        rem = s;
        res = 0;
        b   = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        if (rem > res)
            res = res + 1;
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_center(longint c, ref bit sat);
        if (c > 64'sd8388607)
        begin
            sat = 1;
            c = 8388607;
        end
        else if (c < -64'sd8388608)
        begin
            sat = 1;
            c = -8388608;
        end
        return c[OUT_W-1:0];
    endfunction

    function automatic circle_t circle_through(logic [IN_W-1:0] ax, logic [IN_W-1:0] ay,
                                               logic [IN_W-1:0] bx, logic [IN_W-1:0] by,
                                               logic [IN_W-1:0] qx, logic [IN_W-1:0] qy);
        longint  x1, y1, x2, y2, x3, y3, s1, s2, s3, den, nx, ny, cx, cy, dx, dy;
        longint unsigned rad;
        bit      sat;
        circle_t c;
        x1 = ax; y1 = ay; x2 = bx; y2 = by; x3 = qx; y3 = qy;
        sat = 0;
        c = '{default: '0};
        den = 2 * (x1 * (y2 - y3) + x2 * (y3 - y1) + x3 * (y1 - y2));
        if (den == 0)
        begin
            c.deg = 1'b1;
            return c;
        end
        s1 = x1 * x1 + y1 * y1;
        s2 = x2 * x2 + y2 * y2;
        s3 = x3 * x3 + y3 * y3;
        nx = s1 * (y2 - y3) + s2 * (y3 - y1) + s3 * (y1 - y2);
        ny = s1 * (x3 - x2) + s2 * (x1 - x3) + s3 * (x2 - x1);
        cx = fixed_quotient(nx, den);
        cy = fixed_quotient(ny, den);
        dx = cx - (x1 << FRAC_BITS);
        dy = cy - (y1 << FRAC_BITS);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx > 64'sd16777215 || dy > 64'sd16777215)
        begin
            rad = 16777215;
            sat = 1;
        end
        else
        begin
            rad = nearest_root(dx * dx + dy * dy);
            if (rad > 64'd16777215)
            begin
                rad = 16777215;
                sat = 1;
            end
        end
        c.cx  = clamp_center(cx, sat);
        c.cy  = clamp_center(cy, sat);
        c.rad = rad[OUT_W-1:0];
        c.sat = sat;
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    endtask

    // Send one triple; predict it at the accepting edge
    task automatic send_triple(logic [IN_W-1:0] ax, logic [IN_W-1:0] ay,
                               logic [IN_W-1:0] bx, logic [IN_W-1:0] by,
                               logic [IN_W-1:0] qx, logic [IN_W-1:0] qy);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_x  <= ax; first_y  <= ay;
        second_x <= bx; second_y <= by;
        third_x  <= qx; third_y  <= qy;
        do
            @(posedge clk);
        while (!in_ready);
        pending_circles.insert(pending_circles.size(), circle_through(ax, ay, bx, by, qx, qy));
        n_sent++;
    endtask

    // Output side: random stall bursts, check every accepted result
    initial
    begin
        int      hold;
        circle_t want;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 8);
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_circles.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = pending_circles.pop_front();
                    if (center_x !== want.cx) report_mismatch("center_x", center_x, want.cx);
                    if (center_y !== want.cy) report_mismatch("center_y", center_y, want.cy);
                    if (circle_radius !== want.rad)
                        report_mismatch("circle_radius", circle_radius, want.rad);
                    if (degenerate !== want.deg)
                        report_mismatch("degenerate", degenerate, want.deg);
                    if (saturated !== want.sat)
                        report_mismatch("saturated", saturated, want.sat);
                    n_degen   += want.deg;
                    n_clipped += want.sat;
                end
                n_checked++;
            end
        end
    end

    // Corners, repeated points, collinear lines and huge circles
    task automatic test_directed();
        send_triple(0, 0, 4095, 0, 0, 4095);
        send_triple(4095, 4095, 0, 4095, 4095, 0);
        send_triple(0, 0, 0, 0, 0, 0);
        send_triple(4095, 4095, 4095, 4095, 4095, 4095);
        send_triple(10, 10, 10, 10, 20, 30);
        send_triple(0, 0, 1, 1, 4095, 4095);
        send_triple(0, 5, 100, 5, 4095, 5);
        send_triple(0, 0, 1, 0, 4095, 1);       // nearly collinear: huge center
        send_triple(0, 0, 4095, 1, 4094, 1);
        send_triple(0, 4095, 1, 4095, 4095, 4094);
        send_triple(0, 0, 2, 0, 1, 1);
        send_triple(0, 0, 1, 0, 0, 1);          // tiny circle with rounding
        send_triple(100, 100, 200, 100, 150, 187);
        send_triple(2048, 0, 0, 2048, 4095, 2048);
        send_triple(2730, 1365, 1365, 2730, 3276, 819);
        send_triple(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hFFF, 12'h000);
    endtask

    // Random triples: mostly general, some near collinear, some degenerate
    task automatic test_random(int count);
        logic [IN_W-1:0] p[6];
        int kind, step;
        for (int i = 0; i < count; i++)
        begin
            foreach (p[k]) p[k] = IN_W'($urandom);
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // exactly collinear along a random step
                step = $urandom_range(1, 40);
                p[2] = p[0] + IN_W'(step); p[3] = p[1] + IN_W'(2 * step);
                p[4] = p[0] + IN_W'(3 * step); p[5] = p[1] + IN_W'(6 * step);
            end
            else if (kind == 1)
            begin
                // nearly collinear: far-out center, exercises clipping
                p[3] = p[1] + 1'b1; p[5] = p[1];
            end
            else if (kind == 2)
            begin
                p[2] = p[0]; p[3] = p[1];
            end
            else if (kind == 3)
            begin
                foreach (p[k]) p[k] = IN_W'($urandom_range(0, 15));
            end
            send_triple(p[0], p[1], p[2], p[3], p[4], p[5]);
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        calm     = 0;
        first_x  <= '0; first_y  <= '0;
        second_x <= '0; second_y <= '0;
        third_x  <= '0; third_y  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(700);
        calm = 1;
        test_random(150);
        in_valid <= 1'b0;

        while (pending_circles.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("sent %0d point triples, checked %0d circles", n_sent, n_checked);
        $display("%0d collinear, %0d clipped, %0d mismatches", n_degen, n_clipped, n_errors);
        if (n_errors == 0)
            $display("PASS circumcircle_three_points");
        else
            $display("FAIL circumcircle_three_points");
        $finish;
    end
endmodule

`default_nettype wire
